[hdl/sacl_pkg.sv]
// shared constants and types for the set-associative lru cache tag store
`default_nettype none

package sacl_pkg;

  localparam int MAX_SETS   = 64;
  localparam int MAX_WAYS   = 8;
  localparam int ADDR_WIDTH = 64;

  localparam int SET_W     = $clog2(MAX_SETS);
  localparam int WAY_IDX_W = $clog2(MAX_WAYS);
  localparam int WCNT_W    = $clog2(MAX_WAYS + 1);
  localparam int HALF_WAYS = MAX_WAYS / 2;
  localparam int TREE_LVLS = $clog2(MAX_WAYS);

  typedef enum logic [1:0] {
    CFG_SET_BITS   = 2'd0,
    CFG_BLOCK_BITS = 2'd1,
    CFG_WAYS       = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OUT_HIT   = 2'd0,
    OUT_FILL  = 2'd1,
    OUT_EVICT = 2'd2
  } outcome_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_UPDATE
  } state_e;

  typedef struct packed {
    logic                  valid;
    logic [ADDR_WIDTH-1:0] tag;
    logic [31:0]           stamp;
  } way_t;

  typedef way_t [MAX_WAYS-1:0] row_t;

endpackage

`default_nettype wire

[hdl/set_assoc_cache_lru_sim.sv]
// top level: set-associative cache tag store with lru replacement
//
//  channel | dir | handshake                 | payload
//  --------+-----+---------------------------+-------------------------------------------
//  in      | in  | in_valid_i / in_stall_o   | address_i
//  out     | out | out_valid_o / out_stall_i | outcome_o way_used_o hit/miss/evict_total_o
//  cfg     | in  | cfg_we_i                  | cfg_idx_i cfg_data_i
//
//  one request at a time: accept in idle reads the set row, look compares tags and
//  starts the stamp minimum, update finishes it and writes the row back
//  the result is registered at the write-back; the next request is taken back in idle
//  the store reads as empty right after reset through one valid flop per set
//  a held result blocks only the write-back of the following request
`default_nettype none

module set_assoc_cache_lru_sim import sacl_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [63:0] address_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       outcome_o,
  output logic [2:0]       way_used_o,
  output logic [31:0]      hit_total_o,
  output logic [31:0]      miss_total_o,
  output logic [31:0]      evict_total_o,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [5:0]  cfg_data_i
);

  state_e state_q, state_d;

  logic [2:0] set_bits_q;
  logic [5:0] block_bits_q;
  logic [3:0] ways_q;

  row_t mem_q [MAX_SETS];
  row_t rdata_q;
  logic [MAX_SETS-1:0] set_vld_q;
  logic                row_vld_q;

  logic [SET_W-1:0]      set_q;
  logic [ADDR_WIDTH-1:0] tag_q;

  logic [MAX_WAYS-1:0]  hit_vec_q, empty_vec_q;
  logic [WAY_IDX_W-1:0] hit_idx_q, empty_idx_q;
  logic [WAY_IDX_W-1:0] l1_idx_q   [HALF_WAYS];
  logic [31:0]          l1_stamp_q [HALF_WAYS];
  logic                 l1_used_q  [HALF_WAYS];

  logic [31:0] clock_q, hits_q, misses_q, evict_q;
  logic        out_valid_q;
  logic [1:0]  outcome_q;
  logic [2:0]  way_q;

  logic rd_en, upd_fire, in_fire;

  // address split and effective configuration
  logic [3:0]            sb_eff;
  logic [WCNT_W-1:0]     ways_eff;
  logic [ADDR_WIDTH-1:0] addr_m, addr_sh, tag_d;
  logic [SET_W-1:0]      set_d;

  always_comb begin
    addr_m  = address_i[ADDR_WIDTH-1:0];
    sb_eff  = ({1'b0, set_bits_q} > 4'(SET_W)) ? 4'(SET_W) : {1'b0, set_bits_q};
    addr_sh = addr_m >> block_bits_q;
    set_d   = addr_sh[SET_W-1:0] & ~({SET_W{1'b1}} << sb_eff);
    tag_d   = addr_m >> (7'(block_bits_q) + 7'(sb_eff));
    if (ways_q == 4'd0) begin
      ways_eff = WCNT_W'(1);
    end else if ({1'b0, ways_q} > 5'(MAX_WAYS)) begin
      ways_eff = WCNT_W'(MAX_WAYS);
    end else begin
      ways_eff = WCNT_W'(ways_q);
    end
  end

  assign in_fire = in_valid_i && !in_stall_o;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q   <= 3'd0;
      block_bits_q <= 6'd0;
      ways_q       <= 4'd1;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_SET_BITS)   set_bits_q   <= cfg_data_i[2:0];
      if (cfg_idx_i == CFG_BLOCK_BITS) block_bits_q <= cfg_data_i;
      if (cfg_idx_i == CFG_WAYS)       ways_q       <= cfg_data_i[3:0];
    end
  end

  // fsm
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_LOOK;
      ST_LOOK:   state_d = ST_UPDATE;
      ST_UPDATE: if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    upd_fire   = 1'b0;
    unique case (state_q)
      ST_IDLE:   in_stall_o = 1'b0;
      ST_LOOK:   ;
      ST_UPDATE: upd_fire = !out_valid_q || !out_stall_i;
      default:   ;
    endcase
  end

  assign rd_en = in_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  // row view gated by the per-set valid flop
  row_t row;
  assign row = row_vld_q ? rdata_q : '0;

  // tag compare, free way search, first level of the stamp minimum
  logic [MAX_WAYS-1:0]  hit_vec_d, empty_vec_d;
  logic [WAY_IDX_W-1:0] hit_idx_d, empty_idx_d;

  always_comb begin
    hit_idx_d   = '0;
    empty_idx_d = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      hit_vec_d[w]   = (WCNT_W'(w) < ways_eff) && row[w].valid && (row[w].tag == tag_q);
      empty_vec_d[w] = (WCNT_W'(w) < ways_eff) && !row[w].valid;
    end
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (hit_vec_d[w])   hit_idx_d   = WAY_IDX_W'(w);
      if (empty_vec_d[w]) empty_idx_d = WAY_IDX_W'(w);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_LOOK) begin
      hit_vec_q   <= hit_vec_d;
      empty_vec_q <= empty_vec_d;
      hit_idx_q   <= hit_idx_d;
      empty_idx_q <= empty_idx_d;
      for (int i = 0; i < HALF_WAYS; i++) begin
        if ((WCNT_W'(2 * i + 1) < ways_eff) && (row[2*i+1].stamp < row[2*i].stamp)) begin
          l1_idx_q[i]   <= WAY_IDX_W'(2 * i + 1);
          l1_stamp_q[i] <= row[2*i+1].stamp;
        end else begin
          l1_idx_q[i]   <= WAY_IDX_W'(2 * i);
          l1_stamp_q[i] <= row[2*i].stamp;
        end
        l1_used_q[i] <= WCNT_W'(2 * i) < ways_eff;
      end
    end
  end

  // remaining levels of the minimum, way choice and new row
  logic [WAY_IDX_W-1:0] n_idx   [HALF_WAYS];
  logic [31:0]          n_stamp [HALF_WAYS];
  logic                 n_used  [HALF_WAYS];
  logic [WAY_IDX_W-1:0] way_sel;
  outcome_e             outcome_d;
  logic [31:0]          stamp_new;
  row_t                 row_new;

  always_comb begin
    for (int i = 0; i < HALF_WAYS; i++) begin
      n_idx[i]   = l1_idx_q[i];
      n_stamp[i] = l1_stamp_q[i];
      n_used[i]  = l1_used_q[i];
    end
    for (int lv = 1; lv < TREE_LVLS; lv++) begin
      for (int n = 0; n < HALF_WAYS; n++) begin
        if (((n & ((2 << (lv - 1)) - 1)) == 0) && (n + (1 << (lv - 1)) < HALF_WAYS)) begin
          if (n_used[n + (1 << (lv - 1))] &&
              (n_stamp[n + (1 << (lv - 1))] < n_stamp[n])) begin
            n_idx[n]   = n_idx[n + (1 << (lv - 1))];
            n_stamp[n] = n_stamp[n + (1 << (lv - 1))];
          end
        end
      end
    end
    priority if (|hit_vec_q) begin
      way_sel   = hit_idx_q;
      outcome_d = OUT_HIT;
    end else if (|empty_vec_q) begin
      way_sel   = empty_idx_q;
      outcome_d = OUT_FILL;
    end else begin
      way_sel   = n_idx[0];
      outcome_d = OUT_EVICT;
    end
    stamp_new = clock_q + 32'd1;
    row_new   = row;
    row_new[way_sel] = '{valid: 1'b1, tag: tag_q, stamp: stamp_new};
  end

  // set store
  always_ff @(posedge clk_i) begin
    if (rd_en) rdata_q <= mem_q[set_d];
    if (upd_fire) mem_q[set_q] <= row_new;
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      set_q <= set_d;
      tag_q <= tag_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_vld_q <= '0;
      row_vld_q <= 1'b0;
    end else begin
      if (rd_en)    row_vld_q <= set_vld_q[set_d];
      if (upd_fire) set_vld_q[set_q] <= 1'b1;
    end
  end

  // counters and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_q     <= '0;
      hits_q      <= '0;
      misses_q    <= '0;
      evict_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (upd_fire) begin
        clock_q     <= stamp_new;
        out_valid_q <= 1'b1;
        if (outcome_d == OUT_HIT) hits_q   <= hits_q + 32'd1;
        else                      misses_q <= misses_q + 32'd1;
        if (outcome_d == OUT_EVICT) evict_q <= evict_q + 32'd1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_fire) begin
      outcome_q <= outcome_d;
      way_q     <= 3'(way_sel);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign outcome_o     = outcome_q;
  assign way_used_o    = way_q;
  assign hit_total_o   = hits_q;
  assign miss_total_o  = misses_q;
  assign evict_total_o = evict_q;

  // checks
  a_one_count_per_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_fire |=> (32'(hits_q + misses_q) == 32'($past(hits_q) + $past(misses_q) + 32'd1)))
    else $error("hit plus miss count did not advance by one");

  a_evict_matches_outcome: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_fire |=> ((outcome_q == OUT_EVICT) == (evict_q != $past(evict_q))))
    else $error("eviction count disagrees with outcome");

  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_fire |-> (!out_valid_q || !out_stall_i))
    else $error("held result overwritten");

  a_no_read_during_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rd_en && upd_fire))
    else $error("set store read and written in the same cycle");

endmodule

`default_nettype wire

[tb/set_assoc_cache_lru_sim_tb.sv]
// self-checking testbench for the set-associative lru cache tag store
`timescale 1ns / 1ps

module set_assoc_cache_lru_sim_tb;
  import sacl_pkg::*;

  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int         CYCLE_LIMIT = 200000;

  typedef struct packed {
    outcome_e    outcome;
    logic [2:0]  way;
    logic [31:0] hits;
    logic [31:0] misses;
    logic [31:0] evicts;
  } lookup_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [63:0] address_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  outcome_o;
  logic [2:0]  way_used_o;
  logic [31:0] hit_total_o;
  logic [31:0] miss_total_o;
  logic [31:0] evict_total_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [5:0]  cfg_data_i = '0;

  set_assoc_cache_lru_sim i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .address_i    (address_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .outcome_o    (outcome_o),
    .way_used_o   (way_used_o),
    .hit_total_o  (hit_total_o),
    .miss_total_o (miss_total_o),
    .evict_total_o(evict_total_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  // mirror of the tag store
  bit        line_valid [MAX_SETS*MAX_WAYS];
  bit [63:0] line_tag   [MAX_SETS*MAX_WAYS];
  bit [31:0] line_stamp [MAX_SETS*MAX_WAYS];
  bit [31:0] access_clk, hit_cnt, miss_cnt, evict_cnt;
  bit [2:0]  cfg_set_bits;
  bit [5:0]  cfg_block_bits;
  bit [3:0]  cfg_ways = 4'd1;

  logic [63:0] pending_addr_q[$];
  lookup_t     expected_q[$];
  bit          took_req;
  bit          calm;
  int          send_gap;
  int          stall_left;
  int          err_cnt;
  int          cycle_cnt;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int unsigned eff_set_bits();
    int unsigned sb;
    sb = 0;
    while (sb < cfg_set_bits && (1 << (sb + 1)) <= MAX_SETS) sb++;
    return sb;
  endfunction

  function automatic int unsigned eff_ways();
    if (cfg_ways == 0) return 1;
    if (cfg_ways > MAX_WAYS) return MAX_WAYS;
    return cfg_ways;
  endfunction

  function automatic lookup_t cache_access(logic [63:0] addr);
    int unsigned sb, nw, set_idx, base, shift, victim;
    logic [63:0] tag;
    lookup_t     r;
    bit          done;
    sb = eff_set_bits();
    nw = eff_ways();
    set_idx = (cfg_block_bits >= ADDR_WIDTH) ? 0 :
              int'((addr >> cfg_block_bits) & ((64'd1 << sb) - 64'd1));
    if (set_idx >= MAX_SETS) set_idx = 0;
    shift = cfg_block_bits + sb;
    tag = (shift >= ADDR_WIDTH) ? '0 : addr >> shift;
    base = set_idx * MAX_WAYS;
    access_clk++;
    done = 1'b0;
    r = '0;
    for (int w = 0; w < nw && !done; w++) begin
      if (line_valid[base+w] && line_tag[base+w] == tag) begin
        hit_cnt++;
        line_stamp[base+w] = access_clk;
        r.outcome = OUT_HIT;
        r.way = 3'(w);
        done = 1'b1;
      end
    end
    if (!done) begin
      miss_cnt++;
      for (int w = 0; w < nw && !done; w++) begin
        if (!line_valid[base+w]) begin
          line_valid[base+w] = 1'b1;
          line_tag[base+w] = tag;
          line_stamp[base+w] = access_clk;
          r.outcome = OUT_FILL;
          r.way = 3'(w);
          done = 1'b1;
        end
      end
    end
    if (!done) begin
      evict_cnt++;
      victim = 0;
      for (int w = 1; w < nw; w++)
        if (line_stamp[base+w] < line_stamp[base+victim]) victim = w;
      line_tag[base+victim] = tag;
      line_stamp[base+victim] = access_clk;
      r.outcome = OUT_EVICT;
      r.way = 3'(victim);
    end
    r.hits = hit_cnt;
    r.misses = miss_cnt;
    r.evicts = evict_cnt;
    return r;
  endfunction

  // address built from tag, set and offset under the current split
  function automatic logic [63:0] make_addr(logic [63:0] tag, int unsigned set_idx,
                                            logic [63:0] off);
    int unsigned sb, shift;
    logic [63:0] a;
    sb = eff_set_bits();
    shift = cfg_block_bits + sb;
    a = (shift >= 64) ? '0 : tag << shift;
    a |= (64'(set_idx) & ((64'd1 << sb) - 64'd1)) << cfg_block_bits;
    a |= off & ((64'd1 << cfg_block_bits) - 64'd1);
    return a;
  endfunction

  function automatic logic [63:0] rand_addr();
    logic [63:0] big;
    big = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0, 1: return big;
      2: return make_addr(big, $urandom_range(0, 63), big);
      default: return make_addr(64'($urandom_range(0, eff_ways() + 2)),
                                $urandom_range(0, 3), big);
    endcase
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [5:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_SET_BITS:   cfg_set_bits = data[2:0];
      CFG_BLOCK_BITS: cfg_block_bits = data;
      CFG_WAYS:       cfg_ways = data[3:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // wait until the block has nothing left in flight
  task automatic drain();
    while (pending_addr_q.size() != 0 || in_valid_i || expected_q.size() != 0)
      @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // request driver
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || took_req)) begin
      if (send_gap > 0) begin
        in_valid_i <= 1'b0;
        send_gap--;
      end else if (pending_addr_q.size() > 0) begin
        in_valid_i <= 1'b1;
        address_i  <= pending_addr_q.pop_front();
        if (!calm && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 8);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result stall
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
        if (!calm && $urandom_range(0, 6) == 0) stall_left = $urandom_range(1, 8);
      end
    end
  end

  // result checker and predictor
  always @(posedge clk_i) begin
    lookup_t want;
    if (rst_ni) begin
      cycle_cnt++;
      if (out_valid_o && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $error("result with no request pending");
          err_cnt++;
        end else begin
          want = expected_q.pop_front();
          check_field("outcome", 32'(want.outcome), 32'(outcome_o));
          check_field("way_used", 32'(want.way), 32'(way_used_o));
          check_field("hit_total", want.hits, hit_total_o);
          check_field("miss_total", want.misses, miss_total_o);
          check_field("evict_total", want.evicts, evict_total_o);
        end
      end
      if (in_valid_i && !in_stall_o) expected_q.push_back(cache_access(address_i));
      took_req <= in_valid_i && !in_stall_o;
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk_i);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    logic [5:0] sb_d, bb_d, wy_d;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: one set, tag is the whole address, one way
    pending_addr_q.push_back(64'd0);
    pending_addr_q.push_back(64'd0);
    pending_addr_q.push_back('1);
    pending_addr_q.push_back('1);
    pending_addr_q.push_back(64'd0);
    pending_addr_q.push_back(64'h8000_0000_0000_0000);
    drain();

    // unknown index ignored, set bits saturate, huge block offset, ways clamp
    cfg_write(CFG_UNUSED, 6'h2a);
    cfg_write(CFG_SET_BITS, 6'h07);
    cfg_write(CFG_BLOCK_BITS, 6'h3f);
    cfg_write(CFG_WAYS, 6'h3f);
    pending_addr_q.push_back(64'd0);
    pending_addr_q.push_back('1);
    pending_addr_q.push_back(64'h7fff_ffff_ffff_ffff);
    pending_addr_q.push_back(64'h8000_0000_0000_0000);
    drain();

    // two ways: fill, hit, evict least recently used
    cfg_write(CFG_SET_BITS, 6'd2);
    cfg_write(CFG_BLOCK_BITS, 6'd4);
    cfg_write(CFG_WAYS, 6'd2);
    pending_addr_q.push_back(make_addr(1, 0, 5));
    pending_addr_q.push_back(make_addr(2, 0, 0));
    pending_addr_q.push_back(make_addr(1, 0, 3));
    pending_addr_q.push_back(make_addr(3, 0, 0));
    pending_addr_q.push_back(make_addr(2, 0, 0));
    pending_addr_q.push_back(make_addr(3, 1, 0));
    pending_addr_q.push_back(make_addr(3, 0, 15));
    drain();

    // zero ways acts as one, widest set index
    cfg_write(CFG_WAYS, 6'h30);
    cfg_write(CFG_SET_BITS, 6'd6);
    cfg_write(CFG_BLOCK_BITS, 6'd32);
    pending_addr_q.push_back(make_addr(5, 63, 0));
    pending_addr_q.push_back(make_addr(5, 63, 1));
    pending_addr_q.push_back(make_addr(6, 63, 0));
    pending_addr_q.push_back(make_addr(0, 0, 0));
    drain();

    for (int p = 0; p < 13; p++) begin
      if (p >= 11) calm = 1'b1;
      case ($urandom_range(0, 4))
        0: sb_d = {3'($urandom), 3'd0};
        1: sb_d = {3'($urandom), 3'd7};
        default: sb_d = 6'($urandom);
      endcase
      case ($urandom_range(0, 7))
        0: bb_d = 6'd0;
        1: bb_d = 6'd32;
        2: bb_d = 6'd63;
        3: bb_d = 6'($urandom);
        default: bb_d = 6'($urandom_range(2, 8));
      endcase
      case ($urandom_range(0, 6))
        0: wy_d = {2'($urandom), 4'd0};
        1: wy_d = {2'($urandom), 4'd15};
        2: wy_d = {2'($urandom), 4'd8};
        default: wy_d = {2'($urandom), 4'($urandom_range(1, 8))};
      endcase
      if ($urandom_range(0, 2) == 0) cfg_write(CFG_UNUSED, 6'($urandom));
      cfg_write(CFG_SET_BITS, sb_d);
      cfg_write(CFG_BLOCK_BITS, bb_d);
      cfg_write(CFG_WAYS, wy_d);
      for (int i = 0; i < 50; i++) pending_addr_q.push_back(rand_addr());
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (expected_q.size() != 0) begin
      $error("%0d results never arrived", expected_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/sacl_pkg.sv
hdl/set_assoc_cache_lru_sim.sv
tb/set_assoc_cache_lru_sim_tb.sv
